FILE: src/dshot_multi_frame_builder_core_defines.svh
// ----------------------------------------------------------------------------
// DShot frame builder assertion macros
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef DSHOT_MULTI_FRAME_BUILDER_CORE_DEFINES_SVH
`define DSHOT_MULTI_FRAME_BUILDER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked only outside reset
`define DMFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define DMFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define DMFB_ASSERT(lbl, prop, msg)
`define DMFB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: src/dmfb_pkg.sv
// ----------------------------------------------------------------------------
// DShot frame builder package
// Shared widths, reset values, register indexes, control struct and the
// packet encoding function.
// ----------------------------------------------------------------------------
package dmfb_pkg;

  localparam int ValueW       = 16;
  localparam int TickW        = 16;
  localparam int MaskW        = 4;
  localparam int SlotW        = 5;
  localparam int LaneMax      = 4;
  localparam int FrameBits    = 16;
  localparam int MaxResults   = 18;
  localparam int MotorCountDef = 4;
  localparam int GapSlotsDef  = 2;

  localparam logic [ValueW-1:0] ValueLimit     = 16'h07FF;
  localparam logic [TickW-1:0]  ZeroTicksReset = 16'd150;
  localparam logic [TickW-1:0]  OneTicksReset  = 16'd300;

  // APB register map
  localparam int ApbDataW  = 32;
  localparam int ApbAddrW  = 3;
  localparam logic RegZeroTicks = 1'b0;
  localparam logic RegOneTicks  = 1'b1;

  // one slot request from the sequencer to the output stage
  typedef struct packed {
    logic             load;
    logic [SlotW-1:0] slot;
    logic             last;
    logic             rejected;
    logic             bit_slot;
  } dmfb_emit_t;

  // 12-bit payload (value, telemetry) followed by the nibble XOR checksum
  function automatic logic [FrameBits-1:0] make_packet(input logic [ValueW-1:0] value,
                                                       input logic tele);
    logic [11:0] payload;
    logic [3:0]  csum;
    payload = {value[10:0], tele};
    csum    = payload[3:0] ^ payload[7:4] ^ payload[11:8];
    return {payload, csum};
  endfunction

endpackage

FILE: src/dmfb_if.sv
// ----------------------------------------------------------------------------
// DShot frame builder channels
// Valid/ready channels for throttle commands and for slot results.
// ----------------------------------------------------------------------------
interface dmfb_in_if;
  import dmfb_pkg::*;

  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value_motor0;
  logic [ValueW-1:0] value_motor1;
  logic [ValueW-1:0] value_motor2;
  logic [ValueW-1:0] value_motor3;
  logic [MaskW-1:0]  telemetry_mask;

  modport source (
    output valid, value_motor0, value_motor1, value_motor2, value_motor3, telemetry_mask,
    input  ready
  );
  modport sink (
    input  valid, value_motor0, value_motor1, value_motor2, value_motor3, telemetry_mask,
    output ready
  );
endinterface

interface dmfb_out_if;
  import dmfb_pkg::*;

  logic             valid;
  logic             ready;
  logic [SlotW-1:0] slot_index;
  logic [TickW-1:0] compare_motor0;
  logic [TickW-1:0] compare_motor1;
  logic [TickW-1:0] compare_motor2;
  logic [TickW-1:0] compare_motor3;
  logic             last_slot;
  logic             rejected;

  modport source (
    output valid, slot_index, compare_motor0, compare_motor1, compare_motor2,
           compare_motor3, last_slot, rejected,
    input  ready
  );
  modport sink (
    input  valid, slot_index, compare_motor0, compare_motor1, compare_motor2,
           compare_motor3, last_slot, rejected,
    output ready
  );
endinterface

FILE: src/dmfb_lane.sv
// ----------------------------------------------------------------------------
// DShot motor lane
// Range-checks one motor value, encodes its packet and shifts it out MSB
// first, one bit per slot, as a compare tick count.
// ----------------------------------------------------------------------------
module dmfb_lane (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic                   shift_i,
  input  logic [dmfb_pkg::ValueW-1:0] value_i,
  input  logic                   tele_i,
  input  logic [dmfb_pkg::TickW-1:0]  zero_ticks_i,
  input  logic [dmfb_pkg::TickW-1:0]  one_ticks_i,
  output logic                   over_o,
  output logic [dmfb_pkg::TickW-1:0]  compare_o
);
  import dmfb_pkg::*;

  logic [FrameBits-1:0] word_q, word_d;

  // value out of the 11-bit range
  assign over_o = (value_i > ValueLimit);

  // packet shift register: load on a new command, shift per emitted slot
  always_comb begin
    word_d = word_q;
    if (load_i) begin
      word_d = make_packet(value_i, tele_i);
    end else if (shift_i) begin
      word_d = {word_q[FrameBits-2:0], 1'b0};
    end
  end

  // stored packet clears to zero at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  // current bit picks the pulse width
  assign compare_o = word_q[FrameBits-1] ? one_ticks_i : zero_ticks_i;

endmodule

FILE: src/dmfb_merge.sv
// ----------------------------------------------------------------------------
// DShot lane merge and output stage
// Combines the lanes' range flags into one reject decision and registers
// the lanes' compares with the slot info into the result channel.
// ----------------------------------------------------------------------------
module dmfb_merge (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dmfb_pkg::dmfb_emit_t    ctrl_i,
  input  logic [dmfb_pkg::LaneMax-1:0][dmfb_pkg::TickW-1:0] lane_cmp_i,
  input  logic [dmfb_pkg::LaneMax-1:0] lane_over_i,
  output logic                    any_over_o,
  output logic                    free_o,
  dmfb_out_if.source              slot_o
);
  import dmfb_pkg::*;

  logic                               valid_q, valid_d;
  logic [SlotW-1:0]                   slot_q;
  logic                               last_q;
  logic                               rej_q;
  logic [LaneMax-1:0][TickW-1:0]      cmp_q, cmp_d;

  // a command is rejected if any active lane is out of range
  assign any_over_o = |lane_over_i;

  // output register takes a new slot when empty or being drained
  assign free_o = !valid_q || slot_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.load) begin
      valid_d = 1'b1;
    end else if (slot_o.ready) begin
      valid_d = 1'b0;
    end
  end

  // gap slots and rejected results carry zero compares
  always_comb begin
    for (int m = 0; m < LaneMax; m++) begin
      cmp_d[m] = ctrl_i.bit_slot ? lane_cmp_i[m] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      slot_q <= ctrl_i.slot;
      last_q <= ctrl_i.last;
      rej_q  <= ctrl_i.rejected;
      cmp_q  <= cmp_d;
    end
  end

  assign slot_o.valid          = valid_q;
  assign slot_o.slot_index     = slot_q;
  assign slot_o.compare_motor0 = cmp_q[0];
  assign slot_o.compare_motor1 = cmp_q[1];
  assign slot_o.compare_motor2 = cmp_q[2];
  assign slot_o.compare_motor3 = cmp_q[3];
  assign slot_o.last_slot      = last_q;
  assign slot_o.rejected       = rej_q;

endmodule

FILE: src/dmfb_regs.sv
// ----------------------------------------------------------------------------
// DShot frame builder registers
// APB-style access to the zero-bit and one-bit pulse widths.
// ----------------------------------------------------------------------------
module dmfb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmfb_pkg::ApbAddrW-1:0] paddr,
  input  logic [dmfb_pkg::ApbDataW-1:0] pwdata,
  output logic [dmfb_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output logic [dmfb_pkg::TickW-1:0]    zero_ticks_o,
  output logic [dmfb_pkg::TickW-1:0]    one_ticks_o
);
  import dmfb_pkg::*;

  logic             wr_en;
  logic             reg_sel;
  logic [TickW-1:0] zero_ticks_q;
  logic [TickW-1:0] one_ticks_q;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  // register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_ticks_q <= ZeroTicksReset;
      one_ticks_q  <= OneTicksReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegZeroTicks: zero_ticks_q <= pwdata[TickW-1:0];
        RegOneTicks:  one_ticks_q  <= pwdata[TickW-1:0];
        default:      ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_sel)
      RegZeroTicks: prdata = ApbDataW'(zero_ticks_q);
      RegOneTicks:  prdata = ApbDataW'(one_ticks_q);
      default:      prdata = '0;
    endcase
  end

  assign zero_ticks_o = zero_ticks_q;
  assign one_ticks_o  = one_ticks_q;

  // low address bits do not decode
  logic [1:0] unused_addr;
  assign unused_addr = paddr[1:0];

endmodule

FILE: src/dshot_multi_frame_builder_core.sv
// ----------------------------------------------------------------------------
// DShot multi-motor frame builder
// Turns one four-motor throttle command into a train of per-slot compare
// tick counts: sixteen bit slots, MSB first, then zero gap slots.
// ----------------------------------------------------------------------------
// A command that passes the range check produces min(16 + GAP_SLOT_COUNT, 18)
// slot results, one per clock while the result channel is ready; a command
// with any active motor value above 2047 produces a single rejected result.
// The slot sequencer sets the rate: the next command is taken in the same
// cycle the previous command's final slot enters the output register, so
// full frames stream back to back. Each motor has its own encode/shift
// lane; lanes at or above MOTOR_COUNT are not built and report zero
// compares.
`include "dshot_multi_frame_builder_core_defines.svh"

module dshot_multi_frame_builder_core #(
  parameter int MOTOR_COUNT    = dmfb_pkg::MotorCountDef,
  parameter int GAP_SLOT_COUNT = dmfb_pkg::GapSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dmfb_in_if.sink                       cmd_i,
  dmfb_out_if.source                    slot_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmfb_pkg::ApbAddrW-1:0] paddr,
  input  logic [dmfb_pkg::ApbDataW-1:0] pwdata,
  output logic [dmfb_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import dmfb_pkg::*;

  localparam int TotalSlots = (FrameBits + GAP_SLOT_COUNT > MaxResults) ?
                              MaxResults : FrameBits + GAP_SLOT_COUNT;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(TotalSlots - 1);

  logic [TickW-1:0] zero_ticks;
  logic [TickW-1:0] one_ticks;

  logic                          busy_q;
  logic                          rej_q;
  logic [SlotW-1:0]              slot_q;
  logic                          adv;
  logic                          emit_last;
  logic                          accept;
  logic                          any_over;
  logic                          out_free;
  dmfb_emit_t                    emit;

  logic [LaneMax-1:0][ValueW-1:0] lane_value;
  logic [LaneMax-1:0][TickW-1:0]  lane_cmp;
  logic [LaneMax-1:0]             lane_over;

  // configuration registers
  dmfb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .zero_ticks_o (zero_ticks),
    .one_ticks_o  (one_ticks)
  );

  // slot sequencer handshake
  assign adv       = busy_q && out_free;
  assign emit_last = rej_q || (slot_q == LastSlot);
  assign cmd_i.ready = !busy_q || (adv && emit_last);
  assign accept    = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rej_q  <= 1'b0;
      slot_q <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      rej_q  <= any_over;
      slot_q <= '0;
    end else if (adv && emit_last) begin
      busy_q <= 1'b0;
    end else if (adv) begin
      slot_q <= slot_q + SlotW'(1);
    end
  end

  // motor lanes
  assign lane_value[0] = cmd_i.value_motor0;
  assign lane_value[1] = cmd_i.value_motor1;
  assign lane_value[2] = cmd_i.value_motor2;
  assign lane_value[3] = cmd_i.value_motor3;

  for (genvar m = 0; m < LaneMax; m++) begin : g_lane
    if (m < MOTOR_COUNT) begin : g_on
      dmfb_lane u_lane (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .load_i       (accept && !any_over),
        .shift_i      (adv),
        .value_i      (lane_value[m]),
        .tele_i       (cmd_i.telemetry_mask[m]),
        .zero_ticks_i (zero_ticks),
        .one_ticks_i  (one_ticks),
        .over_o       (lane_over[m]),
        .compare_o    (lane_cmp[m])
      );
    end else begin : g_off
      assign lane_over[m] = 1'b0;
      assign lane_cmp[m]  = '0;
    end
  end

  // slot request into the output stage
  assign emit.load     = adv;
  assign emit.slot     = rej_q ? '0 : slot_q;
  assign emit.last     = emit_last;
  assign emit.rejected = rej_q;
  assign emit.bit_slot = !rej_q && (slot_q < SlotW'(FrameBits));

  dmfb_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (emit),
    .lane_cmp_i  (lane_cmp),
    .lane_over_i (lane_over),
    .any_over_o  (any_over),
    .free_o      (out_free),
    .slot_o      (slot_o)
  );

  // rejected result: single slot zero, final, no pulses
  `DMFB_ASSERT_ALWAYS(a_rej_shape, slot_o.valid && slot_o.rejected |-> slot_o.last_slot && slot_o.slot_index == '0 && slot_o.compare_motor0 == '0 && slot_o.compare_motor3 == '0, "rejected result malformed")
  // sequencer never runs past the frame end
  `DMFB_ASSERT(a_slot_range, busy_q |-> slot_q <= LastSlot, "slot counter past frame end")
  // stalled sequencer holds its place
  `DMFB_ASSERT(a_stall_hold, busy_q && !adv |=> busy_q && $stable(slot_q), "sequencer moved while stalled")
  // final slot without a new command leaves the sequencer idle
  `DMFB_ASSERT(a_end_idle, adv && emit_last && !accept |=> !busy_q, "sequencer busy after frame end")
  // gap slots carry no pulse
  `DMFB_ASSERT(a_gap_zero, slot_o.valid && slot_o.slot_index >= SlotW'(FrameBits) |-> slot_o.compare_motor0 == '0 && slot_o.compare_motor1 == '0 && slot_o.compare_motor2 == '0 && slot_o.compare_motor3 == '0, "gap slot with nonzero compare")

endmodule
